@@ rtl/hds_pkg.sv @@
// hds_pkg: shared widths, register indexes, item kinds and reset values for the
// heat diffusion stencil sweep block. No dependencies.
package hds_pkg;

  localparam int MAX_GRID_DEF = 256;

  localparam int DW        = 16;
  localparam int GS_W      = 9;
  localparam int COEF_W    = 16;
  localparam int FRAC_W    = 16;
  localparam int CFG_IDX_W = 2;
  localparam int SUM_W     = DW + 3;
  localparam int PROD_W    = COEF_W + 1 + SUM_W;

  localparam logic [CFG_IDX_W-1:0] REG_GRID_SIZE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_COEF      = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_BOUNDARY  = 2'd2;

  localparam logic KIND_SAMPLE = 1'b0;
  localparam logic KIND_FLUSH  = 1'b1;

  localparam int                  RST_GRID_SIZE = 16;
  localparam logic [COEF_W-1:0]   RST_COEF      = 16'd1024;
  localparam logic signed [DW-1:0] RST_BOUNDARY = 16'sd1280;

  typedef struct packed {
    logic signed [DW-1:0] north;
    logic signed [DW-1:0] south;
    logic signed [DW-1:0] east;
    logic signed [DW-1:0] west;
    logic signed [DW-1:0] center;
  } taps_t;

  typedef struct packed {
    logic signed [SUM_W-1:0] lap;
    logic signed [DW-1:0]    center;
    logic                    border;
    logic                    last;
  } cell_op_t;

endpackage

@@ rtl/hds_ifs.sv @@
// hds_ifs: valid/ready channel interfaces for config writes, input items and
// result items. Depends on hds_pkg.
interface hds_cfg_if;
  logic                           valid;
  logic                           ready;
  logic [hds_pkg::CFG_IDX_W-1:0]  index;
  logic [hds_pkg::DW-1:0]         data;
  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

interface hds_in_if;
  logic                        valid;
  logic                        ready;
  logic                        kind;
  logic signed [hds_pkg::DW-1:0] temperature;
  modport source (output valid, output kind, output temperature, input ready);
  modport sink (input valid, input kind, input temperature, output ready);
endinterface

interface hds_out_if;
  logic                        valid;
  logic                        ready;
  logic signed [hds_pkg::DW-1:0] new_temperature;
  logic                        last;
  modport source (output valid, output new_temperature, output last, input ready);
  modport sink (input valid, input new_temperature, input last, output ready);
endinterface

@@ rtl/heat_diffusion_stencil_sweep_core.sv @@
// heat_diffusion_stencil_sweep_core: one explicit five-point heat diffusion
// step over a raster-order grid stream. Depends on hds_pkg, hds_ifs,
// hds_window, hds_update.
//
// Takes one beat per clock on grid and gives one beat per clock on cells when
// neither side stalls. A sample that completes row r+1 plus one cell releases
// the cell one row plus one behind it, so the first result needs n+2 samples;
// after the n*n samples, n+1 flush beats (kind 1) drain the rest, the final one
// carrying last. Results leave three register stages (operands, multiply,
// saturate) after the releasing beat. Row history lives in two RAMs of
// MAX_GRID words each; writing grid_size restarts the sweep. cfg is always
// ready; the user must write it only when idle; the block does not enforce it.
module heat_diffusion_stencil_sweep_core #(
  parameter int MAX_GRID = hds_pkg::MAX_GRID_DEF
) (
  input  logic       clk,
  input  logic       rst,
  hds_cfg_if.sink    cfg,
  hds_in_if.sink     grid,
  hds_out_if.source  cells
);

  localparam int NW = $clog2(MAX_GRID + 1);
  localparam int AW = $clog2(MAX_GRID);
  localparam int CW = $clog2(MAX_GRID * MAX_GRID + 1);

  function automatic logic [NW-1:0] sat_size(input logic [hds_pkg::GS_W-1:0] gs);
    int v;
    v = int'(gs);
    if (v < 3) v = 3;
    if (v > MAX_GRID) v = MAX_GRID;
    return NW'(v);
  endfunction

  localparam logic [NW-1:0] N_RST     = sat_size(hds_pkg::GS_W'(hds_pkg::RST_GRID_SIZE));
  localparam logic [CW-1:0] TOTAL_RST = CW'(N_RST) * CW'(N_RST);

  logic [NW-1:0]                 n_size;
  logic [CW-1:0]                 total;
  logic [hds_pkg::COEF_W-1:0]    coef;
  logic signed [hds_pkg::DW-1:0] bval;
  logic [CW-1:0]                 in_cnt;
  logic [NW-1:0]                 out_row;
  logic [NW-1:0]                 out_col;

  logic [NW-1:0]     cfg_n;
  logic              cfg_wr;
  logic              grid_wr;
  logic              accept;
  logic              full;
  logic              primed;
  logic              store;
  logic              emit;
  logic [NW-1:0]     n_last;
  logic              row_end;
  logic              col_end;
  logic              last_cell;
  logic              upd_ready;
  hds_pkg::taps_t    taps;
  hds_pkg::cell_op_t op;

  assign cfg.ready = 1'b1;
  assign cfg_wr    = cfg.valid && cfg.ready;
  assign grid_wr   = cfg_wr && (cfg.index == hds_pkg::REG_GRID_SIZE);
  assign cfg_n     = sat_size(cfg.data[hds_pkg::GS_W-1:0]);

  assign grid.ready = upd_ready;
  assign accept     = grid.valid && grid.ready;
  assign full       = (in_cnt == total);
  assign primed     = (in_cnt >= CW'(n_size) + CW'(1));
  assign store      = accept && (grid.kind == hds_pkg::KIND_SAMPLE) && !full;
  assign emit       = store ? primed : (accept && full);

  assign n_last    = n_size - 1'b1;
  assign row_end   = (out_row == n_last);
  assign col_end   = (out_col == n_last);
  assign last_cell = row_end && col_end;

  always_ff @(posedge clk) begin
    if (rst) begin
      n_size  <= N_RST;
      total   <= TOTAL_RST;
      coef    <= hds_pkg::RST_COEF;
      bval    <= hds_pkg::RST_BOUNDARY;
      in_cnt  <= '0;
      out_row <= '0;
      out_col <= '0;
    end else if (cfg_wr) begin
      case (cfg.index)
        hds_pkg::REG_GRID_SIZE: begin
          n_size  <= cfg_n;
          total   <= CW'(cfg_n) * CW'(cfg_n);
          in_cnt  <= '0;
          out_row <= '0;
          out_col <= '0;
        end
        hds_pkg::REG_COEF: begin
          coef <= cfg.data;
        end
        hds_pkg::REG_BOUNDARY: begin
          bval <= $signed(cfg.data);
        end
        default: begin
        end
      endcase
    end else begin
      if (store) begin
        in_cnt <= in_cnt + 1'b1;
      end
      if (emit) begin
        if (last_cell) begin
          in_cnt  <= '0;
          out_row <= '0;
          out_col <= '0;
        end else if (col_end) begin
          out_col <= '0;
          out_row <= out_row + 1'b1;
        end else begin
          out_col <= out_col + 1'b1;
        end
      end
    end
  end

  hds_window #(.MAX_GRID(MAX_GRID)) u_window (
    .clk  (clk),
    .rst  (rst),
    .clr  (grid_wr),
    .en   (store),
    .len  (AW'(n_last)),
    .din  (grid.temperature),
    .taps (taps)
  );

  always_comb begin
    op.lap    = hds_pkg::SUM_W'(taps.north) + hds_pkg::SUM_W'(taps.south)
              + hds_pkg::SUM_W'(taps.east) + hds_pkg::SUM_W'(taps.west)
              - (hds_pkg::SUM_W'(taps.center) <<< 2);
    op.center = taps.center;
    op.border = (out_row == '0) || (out_col == '0) || row_end || col_end;
    op.last   = last_cell;
  end

  hds_update u_update (
    .clk      (clk),
    .rst      (rst),
    .in_valid (emit),
    .in_ready (upd_ready),
    .op       (op),
    .coef     (coef),
    .bval     (bval),
    .cells    (cells)
  );

endmodule

@@ rtl/hds_ram.sv @@
// hds_ram: generic single-write, single-read RAM with registered read data
// (read-before-write on a shared address). Depends on hds_pkg for defaults.
module hds_ram #(
  parameter int WIDTH = hds_pkg::DW,
  parameter int DEPTH = hds_pkg::MAX_GRID_DEF
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

endmodule

@@ rtl/hds_line_delay.sv @@
// hds_line_delay: programmable-length delay line built on one hds_ram; output
// advances only on enabled beats. Depends on hds_pkg, hds_ram.
module hds_line_delay #(
  parameter int MAX_GRID = hds_pkg::MAX_GRID_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        clr,
  input  logic                        en,
  input  logic [$clog2(MAX_GRID)-1:0] len,
  input  logic signed [hds_pkg::DW-1:0] din,
  output logic signed [hds_pkg::DW-1:0] dout
);

  localparam int AW = $clog2(MAX_GRID);

  logic [AW-1:0]          ptr;
  logic [AW-1:0]          ptr_next;
  logic [hds_pkg::DW-1:0] rd;

  assign ptr_next = (ptr == len - 1'b1) ? '0 : ptr + 1'b1;

  always_ff @(posedge clk) begin
    if (rst || clr) begin
      ptr <= '0;
    end else if (en) begin
      ptr <= ptr_next;
    end
  end

  hds_ram #(
    .WIDTH (hds_pkg::DW),
    .DEPTH (MAX_GRID)
  ) u_ram (
    .clk   (clk),
    .we    (en),
    .waddr (ptr),
    .wdata (din),
    .re    (en),
    .raddr (ptr),
    .rdata (rd)
  );

  assign dout = $signed(rd);

endmodule

@@ rtl/hds_window.sv @@
// hds_window: chain of tap cells and two row delays that presents the five
// stencil neighbors of the cell one row plus one behind the stream.
// Depends on hds_pkg, hds_line_delay.
module hds_window #(
  parameter int MAX_GRID = hds_pkg::MAX_GRID_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          clr,
  input  logic                          en,
  input  logic [$clog2(MAX_GRID)-1:0]   len,
  input  logic signed [hds_pkg::DW-1:0] din,
  output hds_pkg::taps_t                taps
);

  logic signed [hds_pkg::DW-1:0] tap_s;
  logic signed [hds_pkg::DW-1:0] tap_e;
  logic signed [hds_pkg::DW-1:0] tap_t;
  logic signed [hds_pkg::DW-1:0] tap_w;
  logic signed [hds_pkg::DW-1:0] tap_n;

  // newest sample, then the sample a row less one back (E), then T and W one beat apart
  always_ff @(posedge clk) begin
    if (en) begin
      tap_s <= din;
      tap_t <= tap_e;
      tap_w <= tap_t;
    end
  end

  hds_line_delay #(.MAX_GRID(MAX_GRID)) u_row0 (
    .clk  (clk),
    .rst  (rst),
    .clr  (clr),
    .en   (en),
    .len  (len),
    .din  (din),
    .dout (tap_e)
  );

  hds_line_delay #(.MAX_GRID(MAX_GRID)) u_row1 (
    .clk  (clk),
    .rst  (rst),
    .clr  (clr),
    .en   (en),
    .len  (len),
    .din  (tap_t),
    .dout (tap_n)
  );

  assign taps.north  = tap_n;
  assign taps.south  = tap_s;
  assign taps.east   = tap_e;
  assign taps.west   = tap_w;
  assign taps.center = tap_t;

endmodule

@@ rtl/hds_update.sv @@
// hds_update: three-stage elastic pipeline: operands, coefficient multiply,
// shift/add/saturate into the output register. Depends on hds_pkg, hds_ifs.
module hds_update (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  hds_pkg::cell_op_t             op,
  input  logic [hds_pkg::COEF_W-1:0]    coef,
  input  logic signed [hds_pkg::DW-1:0] bval,
  hds_out_if.source                     cells
);

  localparam int SH_W  = hds_pkg::PROD_W - hds_pkg::FRAC_W;
  localparam int ACC_W = SH_W + 1;
  localparam logic signed [ACC_W-1:0] MAX_POS = ACC_W'(32767);
  localparam logic signed [ACC_W-1:0] MIN_NEG = -ACC_W'(32768);

  logic v1;
  logic v2;
  logic v3;
  logic ready1;
  logic ready2;
  logic ready3;

  hds_pkg::cell_op_t                  op1;
  logic signed [hds_pkg::PROD_W-1:0]  prod2;
  logic signed [hds_pkg::DW-1:0]      center2;
  logic                               border2;
  logic                               last2;
  logic signed [hds_pkg::DW-1:0]      res3;
  logic                               last3;

  logic signed [SH_W-1:0]             sh;
  logic signed [ACC_W-1:0]            acc;
  logic signed [hds_pkg::DW-1:0]      sat;

  assign ready3   = !v3 || cells.ready;
  assign ready2   = !v2 || ready3;
  assign ready1   = !v1 || ready2;
  assign in_ready = ready1;

  // arithmetic shift = floor division by 2^16
  assign sh  = $signed(prod2[hds_pkg::PROD_W-1:hds_pkg::FRAC_W]);
  assign acc = ACC_W'(center2) + ACC_W'(sh);

  always_comb begin
    if (acc > MAX_POS) begin
      sat = 16'sh7FFF;
    end else if (acc < MIN_NEG) begin
      sat = -16'sh8000;
    end else begin
      sat = acc[hds_pkg::DW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else begin
      if (ready1) begin
        v1 <= in_valid;
      end
      if (ready2) begin
        v2 <= v1;
      end
      if (ready3) begin
        v3 <= v2;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ready1 && in_valid) begin
      op1 <= op;
    end
    if (ready2 && v1) begin
      prod2   <= $signed({1'b0, coef}) * op1.lap;
      center2 <= op1.center;
      border2 <= op1.border;
      last2   <= op1.last;
    end
    if (ready3 && v2) begin
      res3  <= border2 ? bval : sat;
      last3 <= last2;
    end
  end

  assign cells.valid           = v3;
  assign cells.new_temperature = res3;
  assign cells.last            = last3;

endmodule

@@ rtl/hds_checker.sv @@
// hds_checker: port-level assertions for heat_diffusion_stencil_sweep_core,
// attached by bind. Depends on hds_pkg and the top level's ports.
module hds_checker (
  input logic                 clk,
  input logic                 rst,
  input logic                 cfg_ready,
  input logic                 grid_ready,
  input logic                 cells_valid,
  input logic                 cells_ready,
  input logic [hds_pkg::DW-1:0] cells_value,
  input logic                 cells_last
);

  // stalled result beat holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    cells_valid && !cells_ready |=> cells_valid && $stable(cells_value)
      && $stable(cells_last))
    else $error("result beat changed while stalled");

  a_rst_empty: assert property (@(posedge clk) rst |=> !cells_valid)
    else $error("result valid right after reset");

  // a free sink must never block the input side
  a_no_block: assert property (@(posedge clk) disable iff (rst)
    (!cells_valid || cells_ready) |-> grid_ready)
    else $error("input stalled while output side is free");

  a_cfg_ready: assert property (@(posedge clk) disable iff (rst) cfg_ready)
    else $error("config port not ready");

endmodule

bind heat_diffusion_stencil_sweep_core hds_checker u_hds_checker (
  .clk         (clk),
  .rst         (rst),
  .cfg_ready   (cfg.ready),
  .grid_ready  (grid.ready),
  .cells_valid (cells.valid),
  .cells_ready (cells.ready),
  .cells_value (cells.new_temperature),
  .cells_last  (cells.last)
);
